@@ sv/small_key_value_table_macros.svh @@
// Assertion macros for the small key/value table RTL.
`ifndef SMALL_KEY_VALUE_TABLE_MACROS_SVH
`define SMALL_KEY_VALUE_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define SKVT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skvt assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skvt assertion failed");

`else

`define SKVT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/skvt_pkg.sv @@
// Types, constants and helpers shared by the small key/value table modules.
package skvt_pkg;

    localparam int TABLE_ENTRIES = 4;
    localparam int KEY_CHARS     = 4;

    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int LEN_W   = 3;
    localparam int VAL_W   = 32;
    localparam int STS_W   = 2;
    localparam int ENTRY_W = KEY_W + LEN_W + VAL_W;

    // Stream payload widths, padded to whole bytes
    localparam int S_FIELDS_W = OP_W + KEY_W + LEN_W + VAL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = STS_W + VAL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [STS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_BAD_LENGTH = 2'd2,
        ST_FULL       = 2'd3
    } t_status;

    // Controller -> datapath
    typedef struct packed {
        logic    load;        // capture request
        logic    idx_step;    // advance add scan index
        logic    scan;        // issue next lookup/remove read
        logic    add_write;   // write entry at index, set valid
        logic    rm_clear;    // clear valid of matched entry
        logic    res_set;     // capture result
        logic    res_take;    // result carries matched value
        t_status res_status;
        logic    out_load;    // move result to output register
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_op  op;
        logic len_bad;
        logic free_hit;   // entry at index is free
        logic idx_last;   // index at last entry
        logic rd_hit;     // read entry matches
        logic rd_last;    // read entry was the last one
        logic out_free;   // output register can take a result
    } t_dp_sts;

    // Zero the key bytes at and above the key length
    function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] bytes,
                                                  input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] m;
        m = '0;
        for (int b = 0; b < KEY_W / 8; b++) begin
            if (b < int'(len)) begin
                m[b*8 +: 8] = bytes[b*8 +: 8];
            end
        end
        return m;
    endfunction

endpackage

@@ sv/skvt_ram.sv @@
// Generic single-port RAM with registered read.
module skvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                            i_wdata,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/skvt_ctrl.sv @@
// Control state machine: sequences decode, add scan, lookup/remove scan and result.
module skvt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  skvt_pkg::t_dp_sts i_sts,
    output skvt_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADD,
        S_SRCH,
        S_DONE
    } t_state;

    t_state            r_state;
    t_state            n_state;
    skvt_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op == skvt_pkg::OP_NOP) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = skvt_pkg::ST_NOT_FOUND;
                    n_state        = S_DONE;
                end else if (i_sts.len_bad) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = skvt_pkg::ST_BAD_LENGTH;
                    n_state        = S_DONE;
                end else if (i_sts.op == skvt_pkg::OP_ADD) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_ADD: begin
                if (i_sts.free_hit) begin
                    cmd.add_write  = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = skvt_pkg::ST_OK;
                    n_state        = S_DONE;
                end else if (i_sts.idx_last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = skvt_pkg::ST_FULL;
                    n_state        = S_DONE;
                end else begin
                    cmd.idx_step = 1'b1;
                end
            end
            S_SRCH: begin
                cmd.scan = 1'b1;
                if (i_sts.rd_hit) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = skvt_pkg::ST_OK;
                    cmd.res_take   = (i_sts.op == skvt_pkg::OP_LOOKUP);
                    cmd.rm_clear   = (i_sts.op == skvt_pkg::OP_REMOVE);
                    n_state        = S_DONE;
                end else if (i_sts.rd_last) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = skvt_pkg::ST_NOT_FOUND;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

@@ sv/skvt_dp.sv @@
// Datapath: request registers, entry RAM, valid bits, scan index, result and output registers.
`include "small_key_value_table_macros.svh"

module skvt_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  skvt_pkg::t_dp_cmd                  i_cmd,
    output skvt_pkg::t_dp_sts                  o_sts,
    input  logic [skvt_pkg::OP_W-1:0]          i_opcode,
    input  logic [skvt_pkg::KEY_W-1:0]         i_key_bytes,
    input  logic [skvt_pkg::LEN_W-1:0]         i_key_length,
    input  logic signed [skvt_pkg::VAL_W-1:0]  i_new_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [skvt_pkg::STS_W-1:0]         o_status,
    output logic signed [skvt_pkg::VAL_W-1:0]  o_found_value
);

    // Request
    skvt_pkg::t_op                      r_op;
    logic [skvt_pkg::KEY_W-1:0]         r_key;
    logic [skvt_pkg::LEN_W-1:0]         r_len;
    logic signed [skvt_pkg::VAL_W-1:0]  r_value;

    // Table
    logic [skvt_pkg::TABLE_ENTRIES-1:0] r_valid;
    logic [skvt_pkg::IDX_W-1:0]         r_idx;
    logic                               r_idx_end;
    logic                               r_rd_act;
    logic [skvt_pkg::IDX_W-1:0]         r_rd_idx;
    logic [skvt_pkg::ENTRY_W-1:0]       rd_data;
    logic [skvt_pkg::KEY_W-1:0]         rd_key;
    logic [skvt_pkg::LEN_W-1:0]         rd_len;
    logic signed [skvt_pkg::VAL_W-1:0]  rd_value;

    // Result and output
    skvt_pkg::t_status                  r_res_status;
    logic signed [skvt_pkg::VAL_W-1:0]  r_res_value;
    logic                               r_out_valid;
    logic [skvt_pkg::STS_W-1:0]         r_out_status;
    logic signed [skvt_pkg::VAL_W-1:0]  r_out_value;

    // Entry layout: {value, length, key}
    skvt_ram #(
        .WIDTH (skvt_pkg::ENTRY_W),
        .DEPTH (skvt_pkg::TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_write),
        .i_addr  (r_idx),
        .i_wdata ({r_value, r_len, r_key}),
        .o_rdata (rd_data)
    );

    assign rd_key   = rd_data[skvt_pkg::KEY_W-1:0];
    assign rd_len   = rd_data[skvt_pkg::KEY_W +: skvt_pkg::LEN_W];
    assign rd_value = rd_data[skvt_pkg::KEY_W + skvt_pkg::LEN_W +: skvt_pkg::VAL_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= skvt_pkg::t_op'(i_opcode);
            r_key   <= skvt_pkg::mask_key(i_key_bytes, i_key_length);
            r_len   <= i_key_length;
            r_value <= i_new_value;
        end
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            r_res_value  <= i_cmd.res_take ? rd_value : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
        r_rd_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_idx       <= '0;
            r_idx_end   <= 1'b0;
            r_rd_act    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_idx_end <= 1'b0;
                r_rd_act  <= 1'b0;
            end else begin
                if (i_cmd.idx_step) begin
                    r_idx <= r_idx + 1'b1;
                end
                // one read issued per cycle, stop after the last entry
                r_rd_act <= i_cmd.scan && !r_idx_end;
                if (i_cmd.scan && !r_idx_end) begin
                    if (r_idx == skvt_pkg::IDX_LAST) begin
                        r_idx_end <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            if (i_cmd.add_write) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.rm_clear) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.op       = r_op;
        o_sts.len_bad  = (r_len == '0) ||
                         ({1'b0, r_len} > (skvt_pkg::LEN_W + 1)'(skvt_pkg::KEY_CHARS));
        o_sts.free_hit = !r_valid[r_idx];
        o_sts.idx_last = (r_idx == skvt_pkg::IDX_LAST);
        o_sts.rd_hit   = r_rd_act && r_valid[r_rd_idx] &&
                         (rd_len == r_len) && (rd_key == r_key);
        o_sts.rd_last  = r_rd_act && (r_rd_idx == skvt_pkg::IDX_LAST);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_value;

    `SKVT_ASSERT_SAME(a_add_free_slot, i_clk, i_rst_n, i_cmd.add_write, !r_valid[r_idx])
    `SKVT_ASSERT_NEXT(a_valid_stable, i_clk, i_rst_n, !i_cmd.add_write && !i_cmd.rm_clear, $stable(r_valid))
    `SKVT_ASSERT_SAME(a_value_only_ok, i_clk, i_rst_n, r_out_valid && (r_out_value != '0), r_out_status == skvt_pkg::ST_OK)

endmodule

@@ sv/small_key_value_table.sv @@
// Small key/value table: up to TABLE_ENTRIES keys of 1 to KEY_CHARS bytes, each with a signed
// 32-bit value. One transfer in carries an opcode (lookup, add, remove), the key bytes, the key
// length and a value for add; one transfer out carries a status and the found value. Lookup and
// remove act on the lowest-index valid entry whose stored length and key bytes match exactly;
// add fills the lowest free entry and does not check for duplicates. Items are handled one at a
// time. The entry RAM is read once per cycle at the scan index. A bad length or the unused
// opcode is answered from decode; add scans upward from index 0 for a free entry and reports
// full after the last one; lookup and remove read upward until a hit or the last entry.
// The result sits in an output register, so the next request is taken while it waits.
module small_key_value_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // opcode[1:0], key_bytes[33:2], key_length[36:34], new_value[68:37], zero pad
    input  logic [skvt_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // status[1:0], found_value[33:2], zero pad
    output logic [skvt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata
);

    skvt_pkg::t_dp_cmd                  cmd;
    skvt_pkg::t_dp_sts                  sts;
    logic [skvt_pkg::OP_W-1:0]          in_opcode;
    logic [skvt_pkg::KEY_W-1:0]         in_key_bytes;
    logic [skvt_pkg::LEN_W-1:0]         in_key_length;
    logic signed [skvt_pkg::VAL_W-1:0]  in_new_value;
    logic [skvt_pkg::STS_W-1:0]         out_status;
    logic signed [skvt_pkg::VAL_W-1:0]  out_found_value;

    // Unpack the request transfer
    assign in_opcode     = i_s_axis_tdata[skvt_pkg::OP_W-1:0];
    assign in_key_bytes  = i_s_axis_tdata[skvt_pkg::OP_W +: skvt_pkg::KEY_W];
    assign in_key_length = i_s_axis_tdata[skvt_pkg::OP_W + skvt_pkg::KEY_W +: skvt_pkg::LEN_W];
    assign in_new_value  = i_s_axis_tdata[skvt_pkg::OP_W + skvt_pkg::KEY_W + skvt_pkg::LEN_W
                                         +: skvt_pkg::VAL_W];

    skvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skvt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (in_opcode),
        .i_key_bytes   (in_key_bytes),
        .i_key_length  (in_key_length),
        .i_new_value   (in_new_value),
        .i_out_ready   (i_m_axis_tready),
        .o_out_valid   (o_m_axis_tvalid),
        .o_status      (out_status),
        .o_found_value (out_found_value)
    );

    // Pack the result transfer, zero fill to the byte boundary
    assign o_m_axis_tdata = skvt_pkg::M_TDATA_W'({out_found_value, out_status});

endmodule

@@ bench/tb.sv @@
// Self-checking stream testbench for the small key/value table.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_BLOCKS  = 17;
    localparam int BLOCK_ITEMS    = 100;
    localparam int POOL_KEYS      = 6;
    localparam int MAX_IDLE       = 5;
    localparam int REPORT_LIMIT   = 10;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        skvt_pkg::t_status  status;
        logic signed [31:0] value;
    } t_kv_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_valid = 1'b0;
    logic [skvt_pkg::S_TDATA_W-1:0]   s_data = '0;
    logic                             m_ready = 1'b0;
    logic                             o_s_axis_tready;
    logic                             o_m_axis_tvalid;
    logic [skvt_pkg::M_TDATA_W-1:0]   o_m_axis_tdata;

    // Shadow copy of the table
    logic [31:0]            shadow_key [skvt_pkg::TABLE_ENTRIES];
    logic [2:0]             shadow_len [skvt_pkg::TABLE_ENTRIES];
    logic signed [31:0]     shadow_val [skvt_pkg::TABLE_ENTRIES];
    logic                   shadow_used [skvt_pkg::TABLE_ENTRIES];

    t_kv_result             pending_results [$];
    int                     n_mismatch = 0;
    bit                     idle_on = 1'b1;

    // Keys the random part draws from, so that hits and duplicates are common
    logic [31:0]            pool_key [POOL_KEYS];
    logic [2:0]             pool_len [POOL_KEYS];

    small_key_value_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // Bytes at and above the key length read as zero
    function automatic logic [31:0] key_keep(input logic [2:0] len);
        if (len >= 3'd4) begin
            return 32'hFFFF_FFFF;
        end
        return (32'h1 << (8 * len)) - 32'h1;
    endfunction

    function automatic t_kv_result apply_request(input skvt_pkg::t_op op,
                                                 input logic [31:0] bytes,
                                                 input logic [2:0] len,
                                                 input logic signed [31:0] val);
        t_kv_result  r;
        logic [31:0] key;
        int          hit;
        bit          placed;
        r.status = skvt_pkg::ST_NOT_FOUND;
        r.value  = '0;
        key      = bytes & key_keep(len);
        hit      = -1;
        placed   = 1'b0;
        for (int i = 0; i < skvt_pkg::TABLE_ENTRIES; i++) begin
            if (hit < 0 && shadow_used[i] && shadow_len[i] == len && shadow_key[i] == key) begin
                hit = i;
            end
        end
        if (op != skvt_pkg::OP_NOP && (len == 3'd0 || int'(len) > skvt_pkg::KEY_CHARS)) begin
            r.status = skvt_pkg::ST_BAD_LENGTH;
        end else begin
            case (op)
                skvt_pkg::OP_LOOKUP: begin
                    if (hit >= 0) begin
                        r.status = skvt_pkg::ST_OK;
                        r.value  = shadow_val[hit];
                    end
                end
                skvt_pkg::OP_ADD: begin
                    r.status = skvt_pkg::ST_FULL;
                    for (int i = 0; i < skvt_pkg::TABLE_ENTRIES; i++) begin
                        if (!placed && !shadow_used[i]) begin
                            shadow_key[i]  = key;
                            shadow_len[i]  = len;
                            shadow_val[i]  = val;
                            shadow_used[i] = 1'b1;
                            placed         = 1'b1;
                            r.status       = skvt_pkg::ST_OK;
                        end
                    end
                end
                skvt_pkg::OP_REMOVE: begin
                    if (hit >= 0) begin
                        shadow_used[hit] = 1'b0;
                        r.status         = skvt_pkg::ST_OK;
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    // One request transfer; the expectation is queued at the accepting edge
    task automatic send_request(input skvt_pkg::t_op op, input logic [31:0] bytes,
                                input logic [2:0] len, input logic signed [31:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(skvt_pkg::S_TDATA_W - skvt_pkg::S_FIELDS_W){1'b0}}, val, len, bytes, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(apply_request(op, bytes, len, val));
    endtask

    // Waits on the clock before checking the queue, so the valid drop never meets a raise
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        n_mismatch++;
        if (n_mismatch <= REPORT_LIMIT) begin
            $display("mismatch on %s: expected %08h, got %08h", what, want, got);
        end
    endtask

    // Result side: random stalls, each transfer checked against the oldest expectation
    initial begin : result_check
        int          stall;
        t_kv_result  want;
        logic [1:0]  got_status;
        logic [31:0] got_value;
        @(posedge i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got_status = o_m_axis_tdata[1:0];
            got_value  = o_m_axis_tdata[33:2];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, {30'd0, got_status});
            end else begin
                want = pending_results.pop_front();
                if (got_status != want.status) begin
                    report_mismatch("status", {30'd0, want.status}, {30'd0, got_status});
                end
                if (got_value != want.value) begin
                    report_mismatch("found_value", want.value, got_value);
                end
            end
        end
    end

    task automatic test_empty_table();
        send_request(skvt_pkg::OP_LOOKUP, 32'h1234_5678, 3'd4, 32'sd1);
        send_request(skvt_pkg::OP_REMOVE, 32'h1234_5678, 3'd4, 32'sd2);
    endtask

    // Bad lengths on every real operation; the unused opcode skips the length check
    task automatic test_key_length();
        send_request(skvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 3'd0, 32'sd0);
        send_request(skvt_pkg::OP_ADD,    32'h0000_0041, 3'd5, 32'sd77);
        send_request(skvt_pkg::OP_REMOVE, 32'hA5A5_A5A5, 3'd7, 32'sd0);
        send_request(skvt_pkg::OP_ADD,    32'h0000_0042, 3'd0, 32'sd9);
        send_request(skvt_pkg::OP_NOP,    32'hFFFF_FFFF, 3'd0, 32'sh7FFF_FFFF);
        send_request(skvt_pkg::OP_NOP,    32'h0000_0000, 3'd3, 32'sh8000_0000);
    endtask

    task automatic test_fill_and_full();
        send_request(skvt_pkg::OP_ADD,    32'hFFFF_FFFF, 3'd4, 32'sh7FFF_FFFF);
        send_request(skvt_pkg::OP_ADD,    32'hABCD_EF00, 3'd1, 32'sh8000_0000);
        send_request(skvt_pkg::OP_ADD,    32'h5A5A_3C3C, 3'd2, -32'sd1);
        send_request(skvt_pkg::OP_ADD,    32'h0011_2233, 3'd3, 32'sd0);
        send_request(skvt_pkg::OP_ADD,    32'h0000_0001, 3'd1, 32'sd5);    // table full
        send_request(skvt_pkg::OP_LOOKUP, 32'hDEAD_BE00, 3'd1, 32'sd0);    // stale bytes ignored
        send_request(skvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 3'd3, 32'sd0);    // length must match
        send_request(skvt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 3'd4, 32'sd0);
        send_request(skvt_pkg::OP_REMOVE, 32'h9999_3C3C, 3'd2, 32'sd0);
        send_request(skvt_pkg::OP_ADD,    32'hCC00_0077, 3'd1, 32'sd123);  // reuses freed slot
        send_request(skvt_pkg::OP_LOOKUP, 32'h1234_5677, 3'd1, 32'sd0);
    endtask

    // Same key twice: lookup and remove act on the lower entry
    task automatic test_duplicate_key();
        send_request(skvt_pkg::OP_REMOVE, 32'hFF11_2233, 3'd3, 32'sd0);
        send_request(skvt_pkg::OP_ADD,    32'h0000_0077, 3'd1, -32'sd5);
        send_request(skvt_pkg::OP_LOOKUP, 32'h0000_0077, 3'd1, 32'sd0);
        send_request(skvt_pkg::OP_REMOVE, 32'hFFFF_FF77, 3'd1, 32'sd0);
        send_request(skvt_pkg::OP_LOOKUP, 32'h0000_0077, 3'd1, 32'sd0);
        send_request(skvt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 3'd4, 32'sd0);
        send_request(skvt_pkg::OP_REMOVE, 32'h0000_0000, 3'd1, 32'sd0);
        send_request(skvt_pkg::OP_REMOVE, 32'h0000_0077, 3'd1, 32'sd0);
        wait_drain();
    endtask

    task automatic new_key_pool();
        for (int k = 0; k < POOL_KEYS; k++) begin
            // some keys share bytes with the previous one, under a length drawn anew
            if (k > 0 && $urandom_range(0, 2) == 0) begin
                pool_key[k] = pool_key[k-1];
            end else begin
                pool_key[k] = $urandom;
            end
            pool_len[k] = 3'($urandom_range(1, skvt_pkg::KEY_CHARS));
        end
    endtask

    task automatic test_random_traffic();
        int                 pick;
        int                 k;
        skvt_pkg::t_op      op;
        logic [31:0]        bytes;
        logic [31:0]        keep;
        logic [2:0]         len;
        logic signed [31:0] val;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            new_key_pool();
            idle_on = (blk == 0) || ($urandom_range(0, 3) != 0);
            if (blk == RANDOM_BLOCKS / 2) begin
                wait_drain();
            end
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 36) begin
                    op = skvt_pkg::OP_ADD;
                end else if (pick < 72) begin
                    op = skvt_pkg::OP_LOOKUP;
                end else if (pick < 96) begin
                    op = skvt_pkg::OP_REMOVE;
                end else begin
                    op = skvt_pkg::OP_NOP;
                end
                k     = $urandom_range(0, POOL_KEYS - 1);
                len   = pool_len[k];
                keep  = key_keep(len);
                bytes = (pool_key[k] & keep) | ($urandom & ~keep);
                if ($urandom_range(0, 9) == 0) begin
                    bytes = $urandom;
                    len   = 3'($urandom_range(1, skvt_pkg::KEY_CHARS));
                end
                if ($urandom_range(0, 19) == 0 || op == skvt_pkg::OP_NOP) begin
                    len = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
                    if (op == skvt_pkg::OP_NOP) begin
                        len = 3'($urandom_range(0, 7));
                    end
                end
                case ($urandom_range(0, 15))
                    0:       val = 32'sh8000_0000;
                    1:       val = 32'sh7FFF_FFFF;
                    2:       val = 32'sd0;
                    default: val = $urandom;
                endcase
                send_request(op, bytes, len, val);
            end
        end
    endtask

    initial begin : run_tests
        for (int i = 0; i < skvt_pkg::TABLE_ENTRIES; i++) begin
            shadow_key[i]  = '0;
            shadow_len[i]  = '0;
            shadow_val[i]  = '0;
            shadow_used[i] = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_key_length();
        test_fill_and_full();
        test_duplicate_key();
        test_random_traffic();

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
